[rtl/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int CAPACITY  = 16;
   localparam int DATA_W    = 32;
   localparam int POS_W     = 8;
   localparam int REQ_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int OUT_CNT_W = 5;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT_TAIL = 3'd0,
      REQ_REMOVE_TAIL = 3'd1,
      REQ_INSERT_HEAD = 3'd2,
      REQ_REMOVE_HEAD = 3'd3,
      REQ_INSERT_AT   = 3'd4,
      REQ_REMOVE_AT   = 3'd5
   } req_code_type;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic               ins;
      logic               rem;
      logic [IDX_W-1:0]   idx;
      logic [DATA_W-1:0]  data;
   } cell_ctrl_type;

endpackage

[rtl/pls_cell.sv]
// ----------------------------------------------------------------------------
// pls_cell
// One list entry; shifts with its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module pls_cell
   import pls_pkg::*;
(
   input  logic                 clock,
   input  logic [IDX_W-1:0]     cell_index,
   input  cell_ctrl_type        ctrl,
   input  logic [DATA_W-1:0]    left_value,
   input  logic [DATA_W-1:0]    right_value,
   output logic [DATA_W-1:0]    value,
   output logic                 hit
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   assign hit   = (cell_index == ctrl.idx);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (cell_index > ctrl.idx) begin
            value_in = left_value;
         end else if (hit) begin
            value_in = ctrl.data;
         end
      end else if (ctrl.rem) begin
         if (cell_index >= ctrl.idx) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[rtl/positional_list_store.sv]
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The req_ channel carries one request item: a request code, a value to
// insert and a 1-based position. Inserts go to the tail, the head or a
// position; removals take from the tail, the head or a position. Positions
// below 1 act as 1; positions past the end act as the tail.
// The rsp_ channel returns one item per request: the removed value (zero
// when nothing was removed), a status (done, empty on removal, full on
// insert) and the entry count after the request.
// Every cell shifts at once, so a request completes in the cycle it is
// accepted and its result appears in the next cycle; one item per cycle is
// sustained while rsp_ready is high. The output register holds a result
// while rsp_ready is low; req_ready is high if it is free or emptying.
// Reset empties the list and drops any pending result; entries are not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_store
   import pls_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [REQ_W-1:0]            req_type,
   input  logic signed [DATA_W-1:0]    req_item_value,
   input  logic [POS_W-1:0]            req_position,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DATA_W-1:0]    rsp_removed_value,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [OUT_CNT_W-1:0]        rsp_entry_count
);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_W-1:0]     removed_ff;
   logic [DATA_W-1:0]     removed_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [CNT_W-1:0]      rsp_count_ff;

   cell_ctrl_type         ctrl;
   logic [DATA_W-1:0]     cell_value [CAPACITY];
   logic [CAPACITY-1:0]   cell_hit;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [POS_W-1:0]      pos_eff;
   logic [POS_W-1:0]      pos_m1;
   logic [POS_W:0]        count_ext;
   logic [POS_W:0]        ins_at_idx;
   logic [POS_W:0]        rem_at_idx;
   logic [POS_W:0]        tail_idx;
   logic [DATA_W-1:0]     sel_value;
   logic [31:0]           count_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign pos_eff    = (req_position == '0) ? POS_W'(1) : req_position;
   assign pos_m1     = pos_eff - POS_W'(1);
   assign count_ext  = (POS_W + 1)'(count_ff);
   assign tail_idx   = count_ext - (POS_W + 1)'(1);
   assign ins_at_idx = ({1'b0, pos_m1} > count_ext) ? count_ext : {1'b0, pos_m1};
   assign rem_at_idx = ({1'b0, pos_eff} > count_ext) ? tail_idx : {1'b0, pos_m1};

   // selected entry for removal
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_hit[i]) begin
            sel_value = sel_value | cell_value[i];
         end
      end
   end

   always_comb begin
      ctrl.ins     = 1'b0;
      ctrl.rem     = 1'b0;
      ctrl.idx     = '0;
      ctrl.data    = req_item_value;
      count_in     = count_ff;
      status_in    = STATUS_DONE;
      unique case (req_type)
         REQ_INSERT_TAIL, REQ_INSERT_HEAD, REQ_INSERT_AT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + CNT_W'(1);
               if (req_type == REQ_INSERT_TAIL) begin
                  ctrl.idx = IDX_W'(count_ext);
               end else if (req_type == REQ_INSERT_AT) begin
                  ctrl.idx = IDX_W'(ins_at_idx);
               end
            end
         end
         REQ_REMOVE_TAIL, REQ_REMOVE_HEAD, REQ_REMOVE_AT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ctrl.rem = accept;
               count_in = count_ff - CNT_W'(1);
               if (req_type == REQ_REMOVE_TAIL) begin
                  ctrl.idx = IDX_W'(tail_idx);
               end else if (req_type == REQ_REMOVE_AT) begin
                  ctrl.idx = IDX_W'(rem_at_idx);
               end
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
      if (!accept) begin
         count_in = count_ff;
      end
   end

   assign removed_in   = ctrl.rem ? sel_value : '0;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[g];
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end
      pls_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(g)),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[g]),
         .hit         (cell_hit[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         removed_ff   <= removed_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   assign count_wide        = 32'(rsp_count_ff);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_wide[OUT_CNT_W-1:0];

endmodule

[tb/sv/tb_positional_list_store.sv]
// ----------------------------------------------------------------------------
// tb_positional_list_store
// Self-checking regression for the positional list store.
// ----------------------------------------------------------------------------
// A clocked driver offers request items from a backlog queue and a clocked
// monitor takes result items. Each accepted request runs through a shadow
// list kept in the bench, which yields the expected removed value, status and
// entry count; results are checked in order, field by field. A short directed
// run covers empty and full lists, unknown codes and position clamping, then
// about 1500 random requests swing the list between empty and full. Both
// sides idle at random; the receiver also holds off for long stretches so
// the block backs up, and some requests wait until all results are back.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
   import pls_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_HOLD    = 150;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic [REQ_W-1:0] REQ_RESERVED_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_RESERVED_HI = 3'd7;

   typedef struct {
      logic [REQ_W-1:0]          code;
      logic signed [DATA_W-1:0]  value;
      logic [POS_W-1:0]          pos;
      bit                        drain_first;
   } request_item_type;

   typedef struct {
      logic signed [DATA_W-1:0]  removed;
      logic [STATUS_W-1:0]       status;
      logic [OUT_CNT_W-1:0]      count;
   } list_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [REQ_W-1:0]            req_type = '0;
   logic signed [DATA_W-1:0]    req_item_value = '0;
   logic [POS_W-1:0]            req_position = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]    rsp_removed_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [OUT_CNT_W-1:0]        rsp_entry_count;

   request_item_type            request_backlog[$];
   list_result_type             awaited_results[$];

   logic signed [DATA_W-1:0]    shadow_cells[CAPACITY];
   int                          shadow_len = 0;

   request_item_type            on_offer;
   bit                          offering;
   int                          sent;
   int                          send_gap = 0;
   int                          take_gap = 0;
   int                          rsp_taken = 0;
   int                          req_total = 0;
   int                          rsp_total = 0;
   bit                          stim_done = 1'b0;
   int                          mismatches = 0;
   int                          cycles = 0;
   list_result_type             want;
   list_result_type             got;

   positional_list_store dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // shadow list: shifts on every insert and removal
   function automatic list_result_type apply_list_request(input request_item_type it);
      list_result_type res;
      int p;
      int at;
      res.removed = '0;
      res.status  = STATUS_DONE;
      p = (it.pos == 0) ? 1 : int'(it.pos);
      case (it.code)
         REQ_INSERT_TAIL, REQ_INSERT_HEAD, REQ_INSERT_AT: begin
            if (shadow_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               if (it.code == REQ_INSERT_TAIL) at = shadow_len;
               else if (it.code == REQ_INSERT_HEAD) at = 0;
               else at = (p - 1 > shadow_len) ? shadow_len : p - 1;
               for (int k = shadow_len; k > at; k--) shadow_cells[k] = shadow_cells[k - 1];
               shadow_cells[at] = it.value;
               shadow_len++;
            end
         end
         REQ_REMOVE_TAIL, REQ_REMOVE_HEAD, REQ_REMOVE_AT: begin
            if (shadow_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               if (it.code == REQ_REMOVE_TAIL) at = shadow_len - 1;
               else if (it.code == REQ_REMOVE_HEAD) at = 0;
               else at = (p > shadow_len) ? shadow_len - 1 : p - 1;
               res.removed = shadow_cells[at];
               for (int k = at; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k + 1];
               shadow_len--;
            end
         end
         default: ;
      endcase
      res.count = OUT_CNT_W'(shadow_len);
      return res;
   endfunction

   function automatic void queue_request(input logic [REQ_W-1:0] code,
                                         input logic signed [DATA_W-1:0] value,
                                         input logic [POS_W-1:0] pos,
                                         input bit drain_first);
      request_item_type it;
      it.code        = code;
      it.value       = value;
      it.pos         = pos;
      it.drain_first = drain_first;
      request_backlog.push_back(it);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return -1;
         4: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // mostly short gaps, a few long ones, none at all in calm stretches
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_valid;
         sent = req_total;
         if (req_valid && req_ready) begin
            awaited_results.push_back(apply_list_request(on_offer));
            req_total <= req_total + 1;
            sent = sent + 1;
            offering = 1'b0;
            send_gap = pick_gap(((sent / 100) % 4) == 1);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_backlog.size() > 0 &&
                         !(request_backlog[0].drain_first && rsp_total != sent)) begin
               on_offer = request_backlog.pop_front();
               req_type       <= on_offer.code;
               req_item_value <= on_offer.value;
               req_position   <= on_offer.pos;
               offering = 1'b1;
            end else if (request_backlog.size() == 0) begin
               stim_done <= 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // receiver, with long hold-offs so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
         rsp_taken = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken++;
            if (rsp_taken == 300 || rsp_taken == 1000) take_gap = LONG_HOLD;
            else take_gap = pick_gap(((rsp_taken / 100) % 3) == 2);
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_total <= rsp_total + 1;
         got.removed = rsp_removed_value;
         got.status  = rsp_status;
         got.count   = rsp_entry_count;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: value %0d status %0d count %0d",
                        got.removed, got.status, got.count);
         end else begin
            want = awaited_results.pop_front();
            if (got.removed !== want.removed || got.status !== want.status ||
                got.count !== want.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0d: expected value %0d status %0d count %0d, ",
                            "got value %0d status %0d count %0d"},
                           rsp_total, want.removed, want.status, want.count,
                           got.removed, got.status, got.count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("positional_list_store regression: fail");
         $finish;
      end
   end

   initial begin
      int mode;
      int lean;
      int roll;
      int pick;
      logic [REQ_W-1:0] code;
      logic [POS_W-1:0] pos;

      // empty list, unknown codes
      queue_request(REQ_REMOVE_TAIL, 32'sd5, 8'd1, 1'b0);
      queue_request(REQ_REMOVE_HEAD, 32'sd5, 8'd1, 1'b0);
      queue_request(REQ_REMOVE_AT, 32'sd5, 8'd0, 1'b0);
      queue_request(REQ_RESERVED_LO, -1, 8'd255, 1'b0);
      queue_request(REQ_RESERVED_HI, 32'sh80000000, 8'd0, 1'b0);
      // position clamping on insert
      queue_request(REQ_INSERT_TAIL, 32'sh7fffffff, 8'd0, 1'b0);
      queue_request(REQ_INSERT_HEAD, 32'sh80000000, 8'd0, 1'b0);
      queue_request(REQ_INSERT_AT, 32'sd1, 8'd0, 1'b0);
      queue_request(REQ_INSERT_AT, -1, 8'd255, 1'b0);
      queue_request(REQ_INSERT_AT, 32'sh55555555, 8'd2, 1'b0);
      queue_request(REQ_INSERT_AT, 32'shaaaaaaaa, 8'd6, 1'b0);
      for (int i = 0; i < 10; i++)
         queue_request((i % 2) ? REQ_INSERT_HEAD : REQ_INSERT_TAIL, pick_value(), 8'd0, 1'b0);
      // full list
      queue_request(REQ_INSERT_TAIL, 32'sd7, 8'd0, 1'b0);
      queue_request(REQ_INSERT_HEAD, 32'sd7, 8'd0, 1'b0);
      queue_request(REQ_INSERT_AT, 32'sd7, 8'd3, 1'b0);
      // position clamping on removal
      queue_request(REQ_REMOVE_AT, 32'sd0, 8'd0, 1'b0);
      queue_request(REQ_REMOVE_AT, 32'sd0, 8'd255, 1'b0);
      queue_request(REQ_REMOVE_AT, 32'sd0, 8'd7, 1'b0);

      // random part: fill, drain and mixed stretches
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) mode = $urandom_range(0, 2);
         lean = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 2);
         if (roll < 3) begin
            code = roll[0] ? REQ_RESERVED_LO : REQ_RESERVED_HI;
         end else if ($urandom_range(0, 99) < lean) begin
            code = (pick == 0) ? REQ_INSERT_TAIL : (pick == 1) ? REQ_INSERT_HEAD : REQ_INSERT_AT;
         end else begin
            code = (pick == 0) ? REQ_REMOVE_TAIL : (pick == 1) ? REQ_REMOVE_HEAD : REQ_REMOVE_AT;
         end
         roll = $urandom_range(0, 99);
         if (roll < 10) pos = '0;
         else if (roll < 85) pos = POS_W'($urandom_range(1, CAPACITY + 2));
         else pos = POS_W'($urandom_range(0, 255));
         queue_request(code, pick_value(), pos, n == 0 || $urandom_range(0, 199) == 0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!(stim_done && rsp_total == req_total));
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("positional_list_store regression: pass");
      end else begin
         $display("positional_list_store regression: fail");
      end
      $finish;
   end

endmodule
